@@ sv/tlpf_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpf_pkg
// shared types, sizes and codes of the three-level priority queue
// ----------------------------------------------------------------------------
package tlpf_pkg;

  localparam int LEVELS    = 3;
  localparam int DEPTH     = 16;
  localparam int TAG_WIDTH = 16;
  localparam int ID_WIDTH  = 16;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ADDR_W  = $clog2(LEVELS * DEPTH);
  localparam int TOTAL_W = $clog2(LEVELS * DEPTH + 1);
  localparam int LVL_W   = 2;
  localparam int STAT_W  = 3;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [LVL_W-1:0]   lvl_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ENQUEUED = 3'd0,
    ST_SERVED   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_BADLEVEL = 3'd4
  } status_t;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_SERVE   = 1'b1
  } op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0]  id;
    logic [TAG_WIDTH-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    logic  rd_en;
    addr_t rd_addr;
  } mem_req_t;

  localparam addr_t DEPTH_A = ADDR_W'(DEPTH);
  localparam ptr_t  PTR_LAST = PTR_W'(DEPTH - 1);

  // flat slot address of a level queue entry
  function automatic addr_t slot_addr(input logic [1:0] q, input ptr_t p);
    slot_addr = addr_t'(q) * DEPTH_A + addr_t'(p);
  endfunction

  // circular pointer step
  function automatic ptr_t ptr_advance(input ptr_t p);
    ptr_advance = (p == PTR_LAST) ? '0 : p + ptr_t'(1);
  endfunction

endpackage

@@ sv/tlpf_store.sv @@
// ----------------------------------------------------------------------------
// tlpf_store
// entry memory of all levels, one write and one registered read port
// ----------------------------------------------------------------------------
module tlpf_store (
  input  logic               clk,
  input  tlpf_pkg::mem_req_t req,
  input  tlpf_pkg::entry_t   wr_data,
  output tlpf_pkg::entry_t   rd_data
);

  tlpf_pkg::entry_t mem [tlpf_pkg::LEVELS * tlpf_pkg::DEPTH];
  tlpf_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/three_level_priority_fifo_top.sv @@
// ----------------------------------------------------------------------------
// three_level_priority_fifo_top
// strict-priority queue of three levels, each a circular fifo in one memory
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries one request: op 0 enqueues
//   in_tag at in_level (1 high .. 3 low), op 1 serves the oldest entry of the
//   highest non-empty level. every request returns exactly one result on the
//   out channel (out_valid/out_ready) with status, id, level, tag and the
//   number of entries still waiting.
// result path and throughput
//   enqueue and rejected requests: result registered in the cycle after
//   acceptance, one request per cycle while the output is drained.
//   serve of a waiting entry: the entry memory has a registered read port,
//   so the result passes the read data register and then the output
//   register; no new request is taken until the served result is registered.
// reset
//   rst_n low clears pointers, counts, id counter and the output valid flag;
//   memory contents are not cleared, only written slots are ever read.
// stall
//   the result sits in an output register; while it is not taken no new
//   request is accepted, and a serve in flight waits with its read data held.
// ----------------------------------------------------------------------------
module three_level_priority_fifo_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [0:0]  in_op,
  input  logic [1:0]  in_level,
  input  logic [15:0] in_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_entry_id,
  output logic [1:0]  out_served_level,
  output logic [15:0] out_served_tag,
  output logic [5:0]  out_waiting_total
);

  // queue control state
  tlpf_pkg::state_t state_r, state_nxt;
  tlpf_pkg::ptr_t   head_r [tlpf_pkg::LEVELS];
  tlpf_pkg::ptr_t   head_nxt [tlpf_pkg::LEVELS];
  tlpf_pkg::ptr_t   tail_r [tlpf_pkg::LEVELS];
  tlpf_pkg::ptr_t   tail_nxt [tlpf_pkg::LEVELS];
  tlpf_pkg::cnt_t   cnt_r [tlpf_pkg::LEVELS];
  tlpf_pkg::cnt_t   cnt_nxt [tlpf_pkg::LEVELS];
  tlpf_pkg::total_t total_r, total_nxt;
  logic [tlpf_pkg::ID_WIDTH-1:0] id_r, id_nxt;
  tlpf_pkg::lvl_t   srv_lvl_r, srv_lvl_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  tlpf_pkg::status_t out_status_r, out_status_nxt;
  logic [15:0]      out_id_r, out_id_nxt;
  tlpf_pkg::lvl_t   out_lvl_r, out_lvl_nxt;
  logic [15:0]      out_tag_r, out_tag_nxt;
  logic [5:0]       out_total_r, out_total_nxt;

  // memory side
  tlpf_pkg::mem_req_t mem_req;
  tlpf_pkg::entry_t   wr_data;
  tlpf_pkg::entry_t   rd_data;

  logic       out_free;
  logic       accept;
  logic [1:0] enq_q;
  logic [1:0] srv_q;
  logic       any_waiting;

  tlpf_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == tlpf_pkg::S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign enq_q    = in_level - 2'd1;

  // strict priority: level 1 first
  always_comb begin
    any_waiting = 1'b1;
    if (cnt_r[0] != '0) begin
      srv_q = 2'd0;
    end else if (cnt_r[1] != '0) begin
      srv_q = 2'd1;
    end else if (cnt_r[2] != '0) begin
      srv_q = 2'd2;
    end else begin
      srv_q       = 2'd0;
      any_waiting = 1'b0;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    cnt_nxt     = cnt_r;
    total_nxt   = total_r;
    id_nxt      = id_r;
    srv_lvl_nxt = srv_lvl_r;

    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_lvl_nxt    = out_lvl_r;
    out_tag_nxt    = out_tag_r;
    out_total_nxt  = out_total_r;

    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = tlpf_pkg::slot_addr(enq_q, tail_r[enq_q]);
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = tlpf_pkg::slot_addr(srv_q, head_r[srv_q]);
    wr_data.id      = id_r + tlpf_pkg::ID_WIDTH'(1);
    wr_data.tag     = tlpf_pkg::TAG_WIDTH'(in_tag);

    unique case (state_r)
      tlpf_pkg::S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = '0;
          out_lvl_nxt   = '0;
          out_tag_nxt   = '0;
          out_total_nxt = 6'(total_r);
          if (in_op == tlpf_pkg::OP_ENQUEUE) begin
            if (in_level == 2'd0) begin
              out_status_nxt = tlpf_pkg::ST_BADLEVEL;
            end else if (cnt_r[enq_q] >= tlpf_pkg::CNT_W'(tlpf_pkg::DEPTH)) begin
              out_status_nxt = tlpf_pkg::ST_FULL;
            end else begin
              mem_req.wr_en   = 1'b1;
              id_nxt          = wr_data.id;
              tail_nxt[enq_q] = tlpf_pkg::ptr_advance(tail_r[enq_q]);
              cnt_nxt[enq_q]  = cnt_r[enq_q] + tlpf_pkg::cnt_t'(1);
              total_nxt       = total_r + tlpf_pkg::total_t'(1);
              out_status_nxt  = tlpf_pkg::ST_ENQUEUED;
              out_id_nxt      = 16'(wr_data.id);
              out_lvl_nxt     = in_level;
              out_total_nxt   = 6'(total_r + tlpf_pkg::total_t'(1));
            end
          end else if (!any_waiting) begin
            out_status_nxt = tlpf_pkg::ST_EMPTY;
          end else begin
            // pop now, result follows once read data is back
            out_valid_nxt   = 1'b0;
            mem_req.rd_en   = 1'b1;
            head_nxt[srv_q] = tlpf_pkg::ptr_advance(head_r[srv_q]);
            cnt_nxt[srv_q]  = cnt_r[srv_q] - tlpf_pkg::cnt_t'(1);
            total_nxt       = total_r - tlpf_pkg::total_t'(1);
            srv_lvl_nxt     = srv_q + 2'd1;
            state_nxt       = tlpf_pkg::S_READ;
          end
        end
      end
      tlpf_pkg::S_READ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = tlpf_pkg::ST_SERVED;
          out_id_nxt     = 16'(rd_data.id);
          out_lvl_nxt    = srv_lvl_r;
          out_tag_nxt    = 16'(rd_data.tag);
          out_total_nxt  = 6'(total_r);
          state_nxt      = tlpf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tlpf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlpf_pkg::S_IDLE;
      head_r      <= '{default: '0};
      tail_r      <= '{default: '0};
      cnt_r       <= '{default: '0};
      total_r     <= '0;
      id_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      id_r        <= id_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    srv_lvl_r    <= srv_lvl_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_lvl_r    <= out_lvl_nxt;
    out_tag_r    <= out_tag_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_id      = out_id_r;
  assign out_served_level  = out_lvl_r;
  assign out_served_tag    = out_tag_r;
  assign out_waiting_total = out_total_r;

  // running total tracks the level counts
  a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
    total_r == tlpf_pkg::total_t'(cnt_r[0]) + tlpf_pkg::total_t'(cnt_r[1])
               + tlpf_pkg::total_t'(cnt_r[2]))
    else $error("waiting total out of step with level counts");

  // no level ever holds more than its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= tlpf_pkg::CNT_W'(tlpf_pkg::DEPTH) &&
    cnt_r[1] <= tlpf_pkg::CNT_W'(tlpf_pkg::DEPTH) &&
    cnt_r[2] <= tlpf_pkg::CNT_W'(tlpf_pkg::DEPTH))
    else $error("level count beyond depth");

  // a serve in flight blocks new requests
  a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tlpf_pkg::S_READ |-> !in_ready)
    else $error("request taken while serve read pending");

  // a served entry always names a real level
  a_served_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == tlpf_pkg::ST_SERVED |-> out_lvl_r != 2'd0)
    else $error("served result without level");

  // an accepted serve with entries waiting goes to the read state
  a_serve_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_op == tlpf_pkg::OP_SERVE && any_waiting |=> state_r == tlpf_pkg::S_READ)
    else $error("serve did not start memory read");

endmodule

@@ tb/sv/tb_three_level_priority_fifo_top.sv @@
// ----------------------------------------------------------------------------
// tb_three_level_priority_fifo_top
// self-checking bench for the three-level strict-priority queue: a directed
// table followed by a random mix of enqueue and serve requests with random
// idling on both channels; every result is checked against the expectation
// of its typed directed row, or else against a behavioral
// predictor
module tb_three_level_priority_fifo_top;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 7;
  localparam int RAND_ITEMS   = 1150;
  localparam int RX_HOLD      = 150;     // long receiver hold-off in cycles
  localparam int DRAIN_CYCLES = 8;       // quiet stretch after the last result
  localparam int CYCLE_LIMIT  = 100000;  // run limit in cycles
  localparam int REPORT_CAP   = 50;      // keep the log readable on a bad build
  localparam int DIR_ROWS     = 11;

  // one expected result
  typedef struct {
    tlpf_pkg::status_t status;
    logic [15:0]       id;
    tlpf_pkg::lvl_t    level;
    logic [15:0]       tag;
    logic [5:0]        waiting;
  } outcome_t;

  // one row of the directed table; typed rows carry their own expectation
  typedef struct {
    tlpf_pkg::op_t op;
    logic [1:0]    level;
    logic [15:0]   tag;
    int            reps;
    bit            typed;
    outcome_t      exp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [0:0]  in_op = tlpf_pkg::OP_ENQUEUE;
  logic [1:0]  in_level = '0;
  logic [15:0] in_tag = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_entry_id;
  logic [1:0]  out_served_level;
  logic [15:0] out_served_tag;
  logic [5:0]  out_waiting_total;

  three_level_priority_fifo_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_level          (in_level),
    .in_tag            (in_tag),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_entry_id      (out_entry_id),
    .out_served_level  (out_served_level),
    .out_served_tag    (out_served_tag),
    .out_waiting_total (out_waiting_total)
  );

  // --------------------------------------------------------------------------
  // predictor state: one circular fifo per level plus the id counter
  // --------------------------------------------------------------------------
  logic [15:0] lvl_ids   [tlpf_pkg::LEVELS][tlpf_pkg::DEPTH];
  logic [15:0] lvl_tags  [tlpf_pkg::LEVELS][tlpf_pkg::DEPTH];
  int          lvl_head  [tlpf_pkg::LEVELS] = '{default: 0};
  int          lvl_tail  [tlpf_pkg::LEVELS] = '{default: 0};
  int          lvl_count [tlpf_pkg::LEVELS] = '{default: 0};
  logic [15:0] last_id = '0;

  // results still owed by the block, oldest first
  outcome_t    pending_outcomes[$];

  // bench control and bookkeeping
  bit          idle_on = 1'b1;
  bit          rx_hold_pending = 1'b0;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          requests_sent = 0;
  int          results_seen = 0;
  int          status_seen [5] = '{default: 0};

  // directed table: reset, extremes, each status code and the full level
  stim_row_t dir_table [DIR_ROWS] = '{
    // serve with every level empty, level and tag are don't-care
    '{tlpf_pkg::OP_SERVE,   2'd0, 16'hffff, 1,  1'b1,
      '{tlpf_pkg::ST_EMPTY,    16'd0, 2'd0, 16'd0,    6'd0}},
    // level 0 is rejected and consumes no id
    '{tlpf_pkg::OP_ENQUEUE, 2'd0, 16'hffff, 1,  1'b1,
      '{tlpf_pkg::ST_BADLEVEL, 16'd0, 2'd0, 16'd0,    6'd0}},
    '{tlpf_pkg::OP_ENQUEUE, 2'd3, 16'h0000, 1,  1'b1,
      '{tlpf_pkg::ST_ENQUEUED, 16'd1, 2'd3, 16'd0,    6'd1}},
    '{tlpf_pkg::OP_ENQUEUE, 2'd2, 16'hffff, 1,  1'b1,
      '{tlpf_pkg::ST_ENQUEUED, 16'd2, 2'd2, 16'd0,    6'd2}},
    '{tlpf_pkg::OP_ENQUEUE, 2'd1, 16'h8001, 1,  1'b1,
      '{tlpf_pkg::ST_ENQUEUED, 16'd3, 2'd1, 16'd0,    6'd3}},
    // strict priority: level 1 first, then level 2
    '{tlpf_pkg::OP_SERVE,   2'd3, 16'h1234, 1,  1'b1,
      '{tlpf_pkg::ST_SERVED,   16'd3, 2'd1, 16'h8001, 6'd2}},
    '{tlpf_pkg::OP_SERVE,   2'd0, 16'h0000, 1,  1'b1,
      '{tlpf_pkg::ST_SERVED,   16'd2, 2'd2, 16'hffff, 6'd1}},
    // fill level 1 to its full depth
    '{tlpf_pkg::OP_ENQUEUE, 2'd1, 16'haaaa, 16, 1'b0,
      '{tlpf_pkg::ST_ENQUEUED, 16'd0, 2'd0, 16'd0,    6'd0}},
    // full level is rejected, no id used
    '{tlpf_pkg::OP_ENQUEUE, 2'd1, 16'h5555, 1,  1'b1,
      '{tlpf_pkg::ST_FULL,     16'd0, 2'd0, 16'd0,    6'd17}},
    '{tlpf_pkg::OP_SERVE,   2'd1, 16'h0000, 1,  1'b1,
      '{tlpf_pkg::ST_SERVED,   16'd4, 2'd1, 16'haaaa, 6'd16}},
    '{tlpf_pkg::OP_ENQUEUE, 2'd0, 16'h0000, 1,  1'b1,
      '{tlpf_pkg::ST_BADLEVEL, 16'd0, 2'd0, 16'd0,    6'd16}}
  };

  // next result of the queue for one request, updates the predictor state
  function automatic outcome_t queue_outcome(tlpf_pkg::op_t op, logic [1:0] level,
                                             logic [15:0] tag);
    outcome_t r;
    int       q;
    int       i;
    r.status = tlpf_pkg::ST_EMPTY;
    r.id     = '0;
    r.level  = '0;
    r.tag    = '0;
    q        = -1;
    if (op == tlpf_pkg::OP_ENQUEUE) begin
      if (level == 2'd0) begin
        r.status = tlpf_pkg::ST_BADLEVEL;
      end else begin
        q = int'(level) - 1;
        if (lvl_count[q] >= tlpf_pkg::DEPTH) begin
          r.status = tlpf_pkg::ST_FULL;
        end else begin
          last_id = last_id + 16'd1;
          lvl_ids[q][lvl_tail[q]]  = last_id;
          lvl_tags[q][lvl_tail[q]] = tag;
          lvl_tail[q]              = (lvl_tail[q] + 1) % tlpf_pkg::DEPTH;
          lvl_count[q]++;
          r.status = tlpf_pkg::ST_ENQUEUED;
          r.id     = last_id;
          r.level  = level;
        end
      end
    end else begin
      // highest non-empty level wins
      for (i = tlpf_pkg::LEVELS - 1; i >= 0; i--) begin
        if (lvl_count[i] != 0) begin
          q = i;
        end
      end
      if (q >= 0) begin
        r.status    = tlpf_pkg::ST_SERVED;
        r.id        = lvl_ids[q][lvl_head[q]];
        r.tag       = lvl_tags[q][lvl_head[q]];
        r.level     = tlpf_pkg::lvl_t'(q + 1);
        lvl_head[q] = (lvl_head[q] + 1) % tlpf_pkg::DEPTH;
        lvl_count[q]--;
      end
    end
    r.waiting = 6'(lvl_count[0] + lvl_count[1] + lvl_count[2]);
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v,
                                      logic [15:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      if (fail_count <= REPORT_CAP) begin
        $error("%s mismatch: expected %0d (0x%0h), got %0d (0x%0h)",
               name, exp_v, exp_v, act_v, act_v);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      #CLK_HALF clk = ~clk;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // request driver: optional gap, then hold valid until in_ready at an edge;
  // valid is left high on return so a gapless next request follows directly
  // --------------------------------------------------------------------------
  task automatic issue_request(input tlpf_pkg::op_t op, input logic [1:0] level,
                               input logic [15:0] tag);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_level <= level;
    in_tag   <= tag;
    do begin
      @(posedge clk);
    end while (!in_ready);
    // accepted at this edge, so its expected result is queued now
    pending_outcomes.push_back(queue_outcome(op, level, tag));
    requests_sent++;
  endtask

  // --------------------------------------------------------------------------
  // result receiver: random stall per result, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int       stall;
    outcome_t exp_r;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      if (rx_hold_pending) begin
        // long hold so the block backs up and stalls its input
        rx_hold_pending = 1'b0;
        stall = RX_HOLD;
      end else begin
        stall = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!out_valid);
      results_seen++;
      if (out_status < 3'd5) begin
        status_seen[out_status]++;
      end
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_CAP) begin
          $error("result with no request waiting: status %0d id %0d",
                 out_status, out_entry_id);
        end
      end else begin
        exp_r = pending_outcomes.pop_front();
        check_field("status", 16'(exp_r.status), 16'(out_status));
        check_field("entry_id", exp_r.id, out_entry_id);
        check_field("served_level", 16'(exp_r.level), 16'(out_served_level));
        check_field("served_tag", exp_r.tag, out_served_tag);
        check_field("waiting_total", 16'(exp_r.waiting), 16'(out_waiting_total));
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int            n;
    int            r;
    int            enq_pct;
    tlpf_pkg::op_t op;
    logic [1:0]    level;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; typed rows replace the predicted expectation
    for (r = 0; r < DIR_ROWS; r++) begin
      for (n = 0; n < dir_table[r].reps; n++) begin
        issue_request(dir_table[r].op, dir_table[r].level, dir_table[r].tag);
        if (dir_table[r].typed) begin
          pending_outcomes[pending_outcomes.size() - 1] = dir_table[r].exp;
        end
      end
    end

    // random mix in chunks of changing enqueue weight, so levels both
    // fill to the full limit and drain to all-empty
    enq_pct = 50;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_pct = 25;
          1:       enq_pct = 50;
          default: enq_pct = 85;
        endcase
        // every fourth chunk runs without idling on either side
        idle_on = ((n / 64) % 4) != 3;
      end
      if (n == 300) begin
        rx_hold_pending = 1'b1;
      end
      if (n == 700) begin
        // sender pause until the block has answered everything
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge clk);
      end
      op = ($urandom_range(0, 99) < enq_pct) ? tlpf_pkg::OP_ENQUEUE : tlpf_pkg::OP_SERVE;
      if (op == tlpf_pkg::OP_ENQUEUE && $urandom_range(0, 15) != 0) begin
        level = 2'($urandom_range(1, 3));
      end else begin
        level = 2'($urandom_range(0, 3));
      end
      issue_request(op, level, 16'($urandom));
    end
    in_valid <= 1'b0;

    // wait for the last results, then a short quiet stretch for strays
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d requests (directed table, random mix with stalls), %0d results",
             requests_sent, results_seen);
    $display("run: enqueued %0d, served %0d, all empty %0d, level full %0d, bad level %0d",
             status_seen[tlpf_pkg::ST_ENQUEUED], status_seen[tlpf_pkg::ST_SERVED],
             status_seen[tlpf_pkg::ST_EMPTY], status_seen[tlpf_pkg::ST_FULL],
             status_seen[tlpf_pkg::ST_BADLEVEL]);
    if (fail_count == 0 && pending_outcomes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/tlpf_pkg.sv
sv/tlpf_store.sv
sv/three_level_priority_fifo_top.sv
tb/sv/tb_three_level_priority_fifo_top.sv
